@@ rtl/yse_pkg.sv @@
// Package for the YUV neighbor similarity edge unit.
// Types, register codes and reset constants; depends on nothing.
package yse_pkg;

   // Default line store and frame limits
   localparam int DEFAULT_MAX_WIDTH  = 2048;
   localparam int DEFAULT_MAX_HEIGHT = 2048;

   // Field widths
   localparam int FRAME_SIZE_W = 12;
   localparam int CHANNEL_W    = 8;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 12;
   localparam int PIXEL_W      = 3 * CHANNEL_W;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH    = 3'd0,
      CSR_FRAME_HEIGHT   = 3'd1,
      CSR_LUMA_THRESHOLD = 3'd2,
      CSR_U_THRESHOLD    = 3'd3,
      CSR_V_THRESHOLD    = 3'd4
   } csr_index_type;

   // Register reset values
   localparam logic [FRAME_SIZE_W-1:0] RESET_FRAME_WIDTH    = 12'd2048;
   localparam logic [FRAME_SIZE_W-1:0] RESET_FRAME_HEIGHT   = 12'd2048;
   localparam logic [CHANNEL_W-1:0]    RESET_LUMA_THRESHOLD = 8'd48;
   localparam logic [CHANNEL_W-1:0]    RESET_U_THRESHOLD    = 8'd7;
   localparam logic [CHANNEL_W-1:0]    RESET_V_THRESHOLD    = 8'd6;

   typedef struct packed {
      logic [CHANNEL_W-1:0] v;
      logic [CHANNEL_W-1:0] u;
      logic [CHANNEL_W-1:0] y;
   } pixel_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] luma;
      logic [CHANNEL_W-1:0] u;
      logic [CHANNEL_W-1:0] v;
   } threshold_type;

   typedef struct packed {
      logic edge_up_left;
      logic edge_up;
      logic edge_up_right;
      logic edge_left;
      logic frame_end;
   } result_type;

endpackage

@@ rtl/yse_if.sv @@
// Stream channel interfaces for the YUV neighbor similarity edge unit.
// Request carries one pixel, response one edge set; depends on yse_pkg.
interface yse_req_if import yse_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CHANNEL_W-1:0] pixel_y;
   logic [CHANNEL_W-1:0] pixel_u;
   logic [CHANNEL_W-1:0] pixel_v;

   modport source (output valid, output pixel_y, output pixel_u, output pixel_v,
                   input ready);
   modport sink   (input valid, input pixel_y, input pixel_u, input pixel_v,
                   output ready);
endinterface

interface yse_rsp_if;
   logic valid;
   logic ready;
   logic edge_up_left;
   logic edge_up;
   logic edge_up_right;
   logic edge_left;
   logic frame_end;

   modport source (output valid, output edge_up_left, output edge_up,
                   output edge_up_right, output edge_left, output frame_end,
                   input ready);
   modport sink   (input valid, input edge_up_left, input edge_up,
                   input edge_up_right, input edge_left, input frame_end,
                   output ready);
endinterface

@@ rtl/yuv_neighbor_similarity_edges_unit.sv @@
// YUV neighbor similarity edge unit: one edge set per raster pixel.
// A result enters the response buffer when its request is accepted.
// Throughput: one pixel per cycle while the response buffer has room,
// set by the single line store read port (the up-right neighbor is
// fetched one pixel ahead). Reset: synchronous, active high; clears
// counters, left/up-left neighbors, CSRs, output buffer; not line store.
module yuv_neighbor_similarity_edges_unit import yse_pkg::*; #(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   yse_req_if.sink                req_bus,
   yse_rsp_if.source              rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int IDX_W = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;
   localparam int CMP_W = (IDX_W > FRAME_SIZE_W) ? IDX_W : FRAME_SIZE_W;

   // Configuration registers
   logic [FRAME_SIZE_W-1:0] frame_width_ff;
   logic [FRAME_SIZE_W-1:0] frame_height_ff;
   threshold_type           thresholds_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff     <= RESET_FRAME_WIDTH;
         frame_height_ff    <= RESET_FRAME_HEIGHT;
         thresholds_ff.luma <= RESET_LUMA_THRESHOLD;
         thresholds_ff.u    <= RESET_U_THRESHOLD;
         thresholds_ff.v    <= RESET_V_THRESHOLD;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:    frame_width_ff     <= csr_wr_data;
            CSR_FRAME_HEIGHT:   frame_height_ff    <= csr_wr_data;
            CSR_LUMA_THRESHOLD: thresholds_ff.luma <= csr_wr_data[CHANNEL_W-1:0];
            CSR_U_THRESHOLD:    thresholds_ff.u    <= csr_wr_data[CHANNEL_W-1:0];
            CSR_V_THRESHOLD:    thresholds_ff.v    <= csr_wr_data[CHANNEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective frame size: zero counts as one, saturate at the store limits
   logic [CMP_W-1:0] width_raw;
   logic [CMP_W-1:0] height_raw;
   logic [CMP_W-1:0] width_eff;
   logic [CMP_W-1:0] height_eff;

   always_comb begin
      width_raw  = CMP_W'(frame_width_ff);
      height_raw = CMP_W'(frame_height_ff);
      if (width_raw == '0) begin
         width_eff = CMP_W'(1);
      end else if (width_raw > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = width_raw;
      end
      if (height_raw == '0) begin
         height_eff = CMP_W'(1);
      end else if (height_raw > CMP_W'(MAX_HEIGHT)) begin
         height_eff = CMP_W'(MAX_HEIGHT);
      end else begin
         height_eff = height_raw;
      end
   end

   // Raster position and neighbor registers
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   pixel_type        left_ff;
   pixel_type        up_left_ff;
   pixel_type        up_right_prev_ff;
   pixel_type        first_entry_ff;
   logic             bypass_hit_ff;
   pixel_type        bypass_data_ff;

   logic             req_accept;
   logic             buf_ready;
   pixel_type        cur_pixel;
   logic             last_col;
   logic             last_row;
   logic [COL_W:0]   prefetch_ext;
   logic [COL_W-1:0] prefetch_addr;
   logic [PIXEL_W-1:0] ram_rd_data;
   pixel_type        up_pixel;
   pixel_type        up_right_pixel;

   assign req_bus.ready = buf_ready;
   assign req_accept    = req_bus.valid && buf_ready;
   assign cur_pixel     = '{v: req_bus.pixel_v, u: req_bus.pixel_u, y: req_bus.pixel_y};
   assign last_col      = (CMP_W'(col_ff) + CMP_W'(1)) >= width_eff;
   assign last_row      = (CMP_W'(row_ff) + CMP_W'(1)) >= height_eff;

   // Next raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : ROW_W'(row_ff + 1'b1);
      end else begin
         col_in = COL_W'(col_ff + 1'b1);
      end
   end

   // Fetch the next pixel's up-right neighbor from the line store
   always_comb begin
      prefetch_ext  = {1'b0, col_in} + (COL_W+1)'(1);
      prefetch_addr = (prefetch_ext < (COL_W+1)'(MAX_WIDTH)) ? prefetch_ext[COL_W-1:0] : '0;
   end

   yse_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (col_ff),
      .wr_data (cur_pixel),
      .rd_en   (req_accept),
      .rd_addr (prefetch_addr),
      .rd_data (ram_rd_data)
   );

   // Neighbors of the current pixel; a same-cycle store write is forwarded
   assign up_right_pixel = bypass_hit_ff ? bypass_data_ff : pixel_type'(ram_rd_data);
   assign up_pixel       = (col_ff == '0) ? first_entry_ff : up_right_prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         left_ff    <= '0;
         up_left_ff <= '0;
      end else if (req_accept) begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         left_ff    <= cur_pixel;
         up_left_ff <= up_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         up_right_prev_ff <= up_right_pixel;
         bypass_hit_ff    <= (prefetch_addr == col_ff);
         bypass_data_ff   <= cur_pixel;
         if (col_ff == '0) begin
            first_entry_ff <= cur_pixel;
         end
      end
   end

   // Similarity tests for the four backward directions
   logic sim_up_left;
   logic sim_up;
   logic sim_up_right;
   logic sim_left;

   yse_similarity u_sim_up_left (
      .pixel_a (cur_pixel), .pixel_b (up_left_ff),
      .thresholds (thresholds_ff), .similar (sim_up_left)
   );
   yse_similarity u_sim_up (
      .pixel_a (cur_pixel), .pixel_b (up_pixel),
      .thresholds (thresholds_ff), .similar (sim_up)
   );
   yse_similarity u_sim_up_right (
      .pixel_a (cur_pixel), .pixel_b (up_right_pixel),
      .thresholds (thresholds_ff), .similar (sim_up_right)
   );
   yse_similarity u_sim_left (
      .pixel_a (cur_pixel), .pixel_b (left_ff),
      .thresholds (thresholds_ff), .similar (sim_left)
   );

   // Border gating
   result_type result;

   always_comb begin
      result.edge_up_left  = (row_ff != '0) && (col_ff != '0) && sim_up_left;
      result.edge_up       = (row_ff != '0) && sim_up;
      result.edge_up_right = (row_ff != '0) && !last_col && sim_up_right;
      result.edge_left     = (col_ff != '0) && sim_left;
      result.frame_end     = last_col && last_row;
   end

   // Response buffer
   result_type rsp_data;

   yse_skid_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (buf_ready),
      .in_data   (result),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_data)
   );

   assign rsp_bus.edge_up_left  = rsp_data.edge_up_left;
   assign rsp_bus.edge_up       = rsp_data.edge_up;
   assign rsp_bus.edge_up_right = rsp_data.edge_up_right;
   assign rsp_bus.edge_left     = rsp_data.edge_left;
   assign rsp_bus.frame_end     = rsp_data.frame_end;

   // Assertions
   a_col_wrap: assert property (@(posedge clock) disable iff (reset)
      req_accept && last_col |=> col_ff == '0)
      else $error("column did not wrap at end of row");

   a_col_step: assert property (@(posedge clock) disable iff (reset)
      req_accept && !last_col |=> col_ff == COL_W'($past(col_ff) + 1'b1))
      else $error("column did not advance by one");

   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      req_accept && last_col && last_row |=> row_ff == '0)
      else $error("row did not wrap at end of frame");

   a_frame_end_pos: assert property (@(posedge clock) disable iff (reset)
      req_accept && result.frame_end |-> last_col && last_row)
      else $error("frame end flagged away from the last pixel");

endmodule

@@ rtl/yse_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Read-first on an address collision; no dependencies.
module yse_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/yse_similarity.sv @@
// Similarity test of two YUV pixels against per-channel thresholds.
// Depends on yse_pkg.
module yse_similarity import yse_pkg::*; (
   input  pixel_type     pixel_a,
   input  pixel_type     pixel_b,
   input  threshold_type thresholds,
   output logic          similar
);

   logic [CHANNEL_W-1:0] diff_y;
   logic [CHANNEL_W-1:0] diff_u;
   logic [CHANNEL_W-1:0] diff_v;

   // Absolute channel differences
   always_comb begin
      diff_y = (pixel_a.y > pixel_b.y) ? pixel_a.y - pixel_b.y : pixel_b.y - pixel_a.y;
      diff_u = (pixel_a.u > pixel_b.u) ? pixel_a.u - pixel_b.u : pixel_b.u - pixel_a.u;
      diff_v = (pixel_a.v > pixel_b.v) ? pixel_a.v - pixel_b.v : pixel_b.v - pixel_a.v;
   end

   assign similar = (diff_y <= thresholds.luma) && (diff_u <= thresholds.u)
                 && (diff_v <= thresholds.v);

endmodule

@@ rtl/yse_skid_buffer.sv @@
// Two-entry output buffer for response transactions.
// Keeps the request side open while one result waits; depends on yse_pkg.
module yse_skid_buffer import yse_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic [1:0] count_ff, count_in;
   result_type head_ff, head_in;
   result_type tail_ff, tail_in;
   logic       push;
   logic       pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = head_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Next entry contents and fill count
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case ({push, pop})
         2'b10: begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               head_in = in_data;
            end else begin
               tail_in = in_data;
            end
         end
         2'b01: begin
            count_in = count_ff - 2'd1;
            head_in  = tail_ff;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_in = in_data;
            end else begin
               head_in = tail_ff;
               tail_in = in_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule
